>>> rtl/length_prefixed_frame_deframer_macros.svh
// Assertion helpers for the deframer. They expect clk_i and rst_ni in scope.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
`define LPFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LPFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LPFD_ASSERT(lbl, prop, msg)
`define LPFD_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/lpfd_pkg.sv
`timescale 1ns / 1ps

package lpfd_pkg;

  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhHeader  = 2'd1,
    PhPayload = 2'd2,
    PhEnd     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindStatus = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadStart = 2'd1,
    StTooLong  = 2'd2,
    StBadEnd   = 2'd3
  } status_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgStartMarker = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEndMarker   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBigEndian   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxBuffer   = 3'd3;

  localparam int unsigned MaxBufW = 21;
  localparam int unsigned LenW    = 32;

  typedef struct packed {
    logic [7:0]         start_marker;
    logic [7:0]         end_marker;
    logic               big_endian;
    logic [MaxBufW-1:0] max_buffer_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       abort;
  } item_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data_byte;
    logic            last_payload;
    status_e         status;
    logic [LenW-1:0] payload_length;
  } res_t;

endpackage

>>> rtl/lpfd_in_reg.sv
`timescale 1ns / 1ps

module lpfd_in_reg
  import lpfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o,
  input  logic  advance_i
);

  logic  valid_q;
  item_t item_q;
  logic  load;

  // The held item leaves when the core takes it, so a new one may enter then.
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/lpfd_core.sv
`timescale 1ns / 1ps

module lpfd_core
  import lpfd_pkg::*;
#(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam int unsigned CntW     = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam int unsigned Overhead = LENGTH_BYTES + 2;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] rem_q, rem_d;

  logic [LenW-1:0] hdr_len;
  logic [LenW:0]   frame_size;
  logic            too_long;

  // Length assembly: either shift in from the bottom, or drop the byte into
  // the lane given by the header count.
  always_comb begin
    hdr_len = len_q;
    if (cfg_i.big_endian) begin
      hdr_len = {len_q[LenW-9:0], item_i.rx_byte};
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (i < LENGTH_BYTES && hdr_cnt_q == CntW'(i)) begin
          hdr_len[8*i +: 8] = len_q[8*i +: 8] | item_i.rx_byte;
        end
      end
    end
  end

  assign frame_size = {1'b0, hdr_len} + (LenW + 1)'(Overhead);
  assign too_long   = frame_size > (LenW + 1)'(cfg_i.max_buffer_bytes);

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    len_d       = len_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindData, data_byte: 8'd0, last_payload: 1'b0,
                    status: StOk, payload_length: '0};
    if (step_i) begin
      if (item_i.abort) begin
        phase_d   = PhHunt;
        hdr_cnt_d = '0;
        len_d     = '0;
        rem_d     = '0;
      end else begin
        case (phase_q)
          PhHunt: begin
            if (item_i.rx_byte == cfg_i.start_marker) begin
              phase_d   = PhHeader;
              hdr_cnt_d = '0;
              len_d     = '0;
              rem_d     = '0;
            end else begin
              res_valid_o  = 1'b1;
              res_o.kind   = KindError;
              res_o.status = StBadStart;
            end
          end
          PhHeader: begin
            len_d = hdr_len;
            if (hdr_cnt_q == CntW'(LENGTH_BYTES - 1)) begin
              hdr_cnt_d = '0;
              if (too_long) begin
                phase_d              = PhHunt;
                len_d                = '0;
                rem_d                = '0;
                res_valid_o          = 1'b1;
                res_o.kind           = KindError;
                res_o.status         = StTooLong;
                res_o.payload_length = hdr_len;
              end else begin
                rem_d   = hdr_len;
                phase_d = (hdr_len == '0) ? PhEnd : PhPayload;
              end
            end else begin
              hdr_cnt_d = hdr_cnt_q + CntW'(1);
            end
          end
          PhPayload: begin
            rem_d = (rem_q != '0) ? rem_q - LenW'(1) : rem_q;
            if (rem_d == '0) begin
              phase_d = PhEnd;
            end
            res_valid_o        = 1'b1;
            res_o.kind         = KindData;
            res_o.data_byte    = item_i.rx_byte;
            res_o.last_payload = (rem_q <= LenW'(1));
          end
          PhEnd: begin
            phase_d              = PhHunt;
            hdr_cnt_d            = '0;
            len_d                = '0;
            rem_d                = '0;
            res_valid_o          = 1'b1;
            res_o.kind           = KindStatus;
            res_o.status         = (item_i.rx_byte == cfg_i.end_marker) ? StOk : StBadEnd;
            res_o.payload_length = len_q;
          end
          default: begin
            phase_d = PhHunt;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      hdr_cnt_q <= '0;
      len_q     <= '0;
      rem_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
    end
  end

endmodule

>>> rtl/lpfd_out_reg.sv
`timescale 1ns / 1ps

module lpfd_out_reg
  import lpfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pending_i,
  output logic advance_o,
  input  logic res_valid_i,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;
  logic free;

  assign free      = !valid_q || !out_stall_i;
  assign advance_o = pending_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free) begin
      valid_q <= advance_o && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/length_prefixed_frame_deframer.sv
// A byte moves from the input register through the core; its result, if any, is
// registered in the result register. Throughput: one byte per cycle unless the
// consumer stalls, since input and result registers hand over in the same cycle.
// Reset: asynchronous, active low; hunting for a start byte, registers at their
// default values (start 2, end 3, big-endian length, 65536-byte limit).
`timescale 1ns / 1ps
`include "length_prefixed_frame_deframer_macros.svh"

module length_prefixed_frame_deframer
  import lpfd_pkg::*;
#(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               abort_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         data_byte_o,
  output logic               last_payload_o,
  output logic [1:0]         status_o,
  output logic [LenW-1:0]    payload_length_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MaxBufW-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t in_item;
  item_t held_item;
  logic  held_valid;
  logic  advance;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker     <= 8'd2;
      cfg_q.end_marker       <= 8'd3;
      cfg_q.big_endian       <= 1'b1;
      cfg_q.max_buffer_bytes <= 21'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgStartMarker: cfg_q.start_marker     <= cfg_data_i[7:0];
        CfgEndMarker:   cfg_q.end_marker       <= cfg_data_i[7:0];
        CfgBigEndian:   cfg_q.big_endian       <= cfg_data_i[0];
        CfgMaxBuffer:   cfg_q.max_buffer_bytes <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_item.rx_byte = rx_byte_i;
  assign in_item.abort   = abort_i;

  lpfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .valid_o    (held_valid),
    .item_o     (held_item),
    .advance_i  (advance)
  );

  lpfd_core #(
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (held_item),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pending_i   (held_valid),
    .advance_o   (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign kind_o           = out_res.kind;
  assign data_byte_o      = out_res.data_byte;
  assign last_payload_o   = out_res.last_payload;
  assign status_o         = out_res.status;
  assign payload_length_o = out_res.payload_length;

  // The input side only waits when a result is held and the consumer stalls.
  `LPFD_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without output back-pressure")
  `LPFD_ASSERT_IMP(a_data_clean, out_valid_o && kind_o == KindData, status_o == StOk && payload_length_o == '0, "payload item carries status or length")
  `LPFD_ASSERT_IMP(a_ctrl_clean, out_valid_o && kind_o != KindData, data_byte_o == 8'd0 && !last_payload_o, "status item carries payload data")
  `LPFD_ASSERT_IMP(a_bad_start_len, out_valid_o && kind_o == KindError && status_o == StBadStart, payload_length_o == '0, "bad start error carries a length")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lpfd_pkg::*;

  localparam int unsigned LenBytes      = 4;
  localparam int unsigned FrameOverhead = LenBytes + 2;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainLimit    = 5000;
  localparam int unsigned SettleCycles  = 6;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  class frame_scoreboard;
    logic [7:0]         start_marker;
    logic [7:0]         end_marker;
    logic               big_endian;
    logic [MaxBufW-1:0] max_buffer;
    phase_e             rx_phase;
    logic [2:0]         hdr_count;
    logic [LenW-1:0]    length_acc;
    logic [LenW-1:0]    bytes_left;
    res_t               expected_q[$];
    int unsigned        mismatches;

    function new();
      start_marker = 8'd2;
      end_marker   = 8'd3;
      big_endian   = 1'b1;
      max_buffer   = 21'd65536;
      mismatches   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      rx_phase   = PhHunt;
      hdr_count  = '0;
      length_acc = '0;
      bytes_left = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [MaxBufW-1:0] data);
      case (idx)
        CfgStartMarker: start_marker = data[7:0];
        CfgEndMarker:   end_marker   = data[7:0];
        CfgBigEndian:   big_endian   = data[0];
        CfgMaxBuffer:   max_buffer   = data;
        default: ;
      endcase
    endfunction

    // Works out what one accepted byte produces and queues it.
    function void note_byte(logic [7:0] b, logic ab);
      res_t r;
      bit   produced;
      r = '0;
      produced = 1'b0;
      if (ab) begin
        clear_frame();
      end else begin
        case (rx_phase)
          PhHunt: begin
            if (b == start_marker) begin
              clear_frame();
              rx_phase = PhHeader;
            end else begin
              produced = 1'b1;
              r.kind   = KindError;
              r.status = StBadStart;
            end
          end
          PhHeader: begin
            if (big_endian) begin
              length_acc = {length_acc[23:0], b};
            end else if (hdr_count < LenBytes) begin
              length_acc = length_acc | (32'(b) << (8 * hdr_count));
            end
            hdr_count = hdr_count + 3'd1;
            if (hdr_count >= LenBytes) begin
              hdr_count = '0;
              // Done in 64 bits so that a length close to the top cannot wrap.
              if (64'(length_acc) + 64'(FrameOverhead) > 64'(max_buffer)) begin
                produced = 1'b1;
                r.kind   = KindError;
                r.status = StTooLong;
                r.payload_length = length_acc;
                clear_frame();
              end else begin
                bytes_left = length_acc;
                rx_phase   = (length_acc == 0) ? PhEnd : PhPayload;
              end
            end
          end
          PhPayload: begin
            produced = 1'b1;
            r.kind = KindData;
            r.data_byte = b;
            r.last_payload = (bytes_left <= 1);
            if (bytes_left != 0) bytes_left = bytes_left - 1;
            if (bytes_left == 0) rx_phase = PhEnd;
          end
          default: begin
            produced = 1'b1;
            r.kind   = KindStatus;
            r.status = (b == end_marker) ? StOk : StBadEnd;
            r.payload_length = length_acc;
            clear_frame();
          end
        endcase
      end
      if (produced) expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last,
                               logic [1:0] status, logic [LenW-1:0] len);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d data %0h status %0d length %0h",
               kind, data, status, len);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, kind);
        mismatches++;
      end
      if (data !== e.data_byte) begin
        $error("data_byte: expected %0h, actual %0h", e.data_byte, data);
        mismatches++;
      end
      if (last !== e.last_payload) begin
        $error("last_payload: expected %0d, actual %0d", e.last_payload, last);
        mismatches++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        mismatches++;
      end
      if (len !== e.payload_length) begin
        $error("payload_length: expected %0h, actual %0h", e.payload_length, len);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i;
  logic               abort_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         kind_o;
  logic [7:0]         data_byte_o;
  logic               last_payload_o;
  logic [1:0]         status_o;
  logic [LenW-1:0]    payload_length_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [MaxBufW-1:0] cfg_data_i;

  frame_scoreboard sb = new();
  int unsigned     items_sent;
  int unsigned     src_gap_max;
  int unsigned     snk_gap_max;
  bit              hold_req;

  length_prefixed_frame_deframer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .abort_i          (abort_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .last_payload_o   (last_payload_o),
    .status_o         (status_o),
    .payload_length_o (payload_length_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Inputs are noted before outputs are checked, so the order holds at any latency.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(rx_byte_i, abort_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(kind_o, data_byte_o, last_payload_o, status_o, payload_length_o);
      end
    end
  end

  function automatic int unsigned draw_gap(int unsigned max_gap);
    return (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
  endfunction

  function automatic int unsigned pick_idle_max();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4;
      default: return 13;
    endcase
  endfunction

  // Result side: a random hold-off before every item, or the long one when asked.
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = hold_req ? HoldCycles : draw_gap(snk_gap_max);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ab);
    int unsigned gap;
    gap = draw_gap(src_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    abort_i    <= ab;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Sends start, length and, if the length fits, payload and end byte.
  // A non-negative abort_at within the frame sends an abort in place of that item and drops the rest.
  task automatic send_frame(input logic [LenW-1:0] len, input bit good_end,
                            input int abort_at);
    logic [7:0] seq[$];
    int         i;
    seq.push_back(sb.start_marker);
    for (i = 0; i < LenBytes; i++) begin
      if (sb.big_endian) seq.push_back(len[8*(LenBytes-1-i) +: 8]);
      else seq.push_back(len[8*i +: 8]);
    end
    if (64'(len) + 64'(FrameOverhead) <= 64'(sb.max_buffer)) begin
      for (i = 0; i < int'(len); i++) seq.push_back(8'($urandom));
      if (good_end) seq.push_back(sb.end_marker);
      else seq.push_back(sb.end_marker + 8'($urandom_range(1, 255)));
    end
    for (i = 0; i < seq.size() && i != abort_at; i++) send_byte(seq[i], 1'b0);
    if (abort_at >= 0 && abort_at < seq.size()) send_byte(8'($urandom), 1'b1);
  endtask

  function automatic logic [LenW-1:0] pick_length();
    int unsigned room;
    int unsigned cap;
    room = (sb.max_buffer >= FrameOverhead) ? sb.max_buffer - FrameOverhead : 0;
    cap  = ($urandom_range(0, 19) == 0) ? 100 : 24;
    if (room > cap) room = cap;
    return $urandom_range(0, room);
  endfunction

  function automatic logic [LenW-1:0] too_long_length();
    logic [LenW-1:0] len;
    case ($urandom_range(0, 3))
      0: len = (sb.max_buffer >= FrameOverhead) ?
               32'(sb.max_buffer) - FrameOverhead + 1 : 32'd0;
      1: len = 32'hFFFF_FFFF;
      2: len = 32'hFFFF_FFFA;
      default: len = $urandom;
    endcase
    if (64'(len) + 64'(FrameOverhead) <= 64'(sb.max_buffer)) len = 32'hFFFF_FFFF;
    return len;
  endfunction

  task automatic wait_drained();
    int unsigned n;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    n = 0;
    while (sb.expected_q.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.mismatches += sb.expected_q.size();
      sb.expected_q.delete();
    end
    // Items that give no result may still be in flight.
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MaxBufW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  // Upper data bits of the narrow registers carry junk, which must be ignored.
  task automatic configure(input logic [7:0] start_b, input logic [7:0] end_b,
                           input logic big_end, input logic [MaxBufW-1:0] limit,
                           input bit touch_unused);
    wait_drained();
    write_reg(CfgStartMarker, {13'($urandom), start_b});
    write_reg(CfgEndMarker, {13'($urandom), end_b});
    write_reg(CfgBigEndian, {20'($urandom), big_end});
    write_reg(CfgMaxBuffer, limit);
    if (touch_unused) write_reg(CfgUnused, 21'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_burst(input int unsigned count);
    int unsigned stop_at;
    int unsigned sel;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        src_gap_max = pick_idle_max();
        snk_gap_max = pick_idle_max();
      end
      sel = $urandom_range(0, 99);
      if (sel < 68) begin
        send_frame(pick_length(), $urandom_range(0, 6) != 0, -1);
      end else if (sel < 78) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      end else if (sel < 86) begin
        send_frame(too_long_length(), 1'b1, -1);
      end else if (sel < 95) begin
        send_frame(pick_length(), 1'b1, $urandom_range(0, 8));
      end else begin
        send_byte(8'($urandom), 1'b1);
      end
    end
  endtask

  initial begin : watchdog
    #20_000_000;
    $display("length_prefixed_frame_deframer regression: fail");
    $finish;
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    abort_i     = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    items_sent  = 0;
    src_gap_max = 13;
    snk_gap_max = 13;
    hold_req    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items with the registers at their reset values.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_frame(32'd0, 1'b1, -1);
    send_frame(32'd1, 1'b0, -1);
    send_frame(32'hFFFF_FFFF, 1'b1, -1);
    send_frame(32'd2, 1'b1, 2);
    send_byte(8'h00, 1'b1);

    // Same value for both markers, little-endian length, 1048576-byte limit.
    configure(8'h7E, 8'h7E, 1'b0, 21'd1048576, 1'b0);
    send_frame(32'd3, 1'b1, -1);
    send_frame(32'hFFFF_FFFA, 1'b1, -1);
    random_burst(150);

    configure(8'h00, 8'hFF, 1'b1, 21'd40, 1'b0);
    send_frame(32'd34, 1'b1, -1);
    send_frame(32'd35, 1'b1, -1);
    random_burst(120);

    // Only empty frames fit at a limit equal to the frame overhead.
    configure(8'hFF, 8'h00, 1'b0, 21'd6, 1'b0);
    random_burst(100);

    // Limits below the frame overhead reject every frame.
    configure(8'hA5, 8'h5A, 1'b1, 21'd5, 1'b0);
    random_burst(40);
    configure(8'h5A, 8'hA5, 1'b0, 21'd0, 1'b1);
    random_burst(30);

    configure(8'($urandom), 8'($urandom), 1'($urandom), 21'h1F_FFFF, 1'b0);
    // Long receiver hold-off while the sender keeps pushing a payload.
    hold_req    = 1'b1;
    src_gap_max = 0;
    send_frame(32'd60, 1'b1, -1);
    random_burst(150);

    configure(8'($urandom), 8'($urandom), 1'($urandom), 21'($urandom_range(6, 300)), 1'b0);
    random_burst(160);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("length_prefixed_frame_deframer regression: pass");
    end else begin
      $display("length_prefixed_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule

>>> length_prefixed_frame_deframer.f
+incdir+rtl
rtl/lpfd_pkg.sv
rtl/lpfd_in_reg.sv
rtl/lpfd_core.sv
rtl/lpfd_out_reg.sv
rtl/length_prefixed_frame_deframer.sv
test/testbench.sv
